### hdl/dmp_pkg.sv
// Shared constants, codes and types of the DNS message parser.
`timescale 1ns / 1ps
package dmp_pkg;

	localparam int BUFFER_BYTES = 512;
	localparam int NAME_BUFFER  = 256;
	localparam int MAX_HOPS     = 16;

	localparam int ADDR_W = $clog2(BUFFER_BYTES);
	localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
	localparam int NC_W   = $clog2(NAME_BUFFER);
	localparam int HOP_W  = $clog2(MAX_HOPS + 1);
	localparam int POS_W  = 16;
	localparam int ACC_W  = 80;

	localparam int HDR_BYTES = 12;
	localparam int ANS_FIXED = 10;
	localparam int Q_FIXED   = 4;

	localparam logic [7:0] PTR_MARK  = 8'hC0;
	localparam logic [7:0] LABEL_MAX = 8'd63;
	localparam logic [7:0] DOT_CHAR  = 8'h2E;

	typedef enum logic [2:0] {
		KIND_HEADER = 3'd0,
		KIND_COUNTS = 3'd1,
		KIND_CHAR   = 3'd2,
		KIND_QTAIL  = 3'd3,
		KIND_ATAIL  = 3'd4,
		KIND_RDATA  = 3'd5,
		KIND_FINISH = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		ERR_OK       = 3'd0,
		ERR_SHORT    = 3'd1,
		ERR_NAME_OUT = 3'd2,
		ERR_LABEL    = 3'd3,
		ERR_FIELDS   = 3'd4,
		ERR_RDATA    = 3'd5,
		ERR_HOPS     = 3'd6,
		ERR_NO_PKT   = 3'd7
	} err_t;

	typedef enum logic [7:0] {
		PH_NONE   = 8'b0000_0001,
		PH_HEADER = 8'b0000_0010,
		PH_COUNTS = 8'b0000_0100,
		PH_RECORD = 8'b0000_1000,
		PH_QNAME  = 8'b0001_0000,
		PH_ANAME  = 8'b0010_0000,
		PH_RDATA  = 8'b0100_0000,
		PH_DONE   = 8'b1000_0000
	} phase_t;

	typedef enum logic [2:0] {
		G_HDR = 3'd0,
		G_CNT = 3'd1,
		G_QT  = 3'd2,
		G_AT  = 3'd3,
		G_RD  = 3'd4,
		G_CHR = 3'd5,
		G_LBL = 3'd6,
		G_PTR = 3'd7
	} gather_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] w1;
		logic [15:0] w2;
		logic [15:0] w3;
		logic [15:0] w4;
		logic [31:0] ttl;
		logic        qf;
		err_t        err;
		logic        last;
	} item_t;

endpackage

### hdl/dns_message_parser.sv
// Top level of the DNS message parser: packet buffer and parse sequencer.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                  payload
//  -------   ---------  -------------------------  ------------------------------------
//  command   in         start & !busy              command, data_byte, end_of_packet
//  result    out        strobe (one cycle)         record_kind, first/second/third/
//                                                  fourth_word, time_to_live,
//                                                  query_failed, error_code,
//                                                  last_of_packet
//
//  A load leaves busy low, so bytes can stream in every cycle.
//  An advance reads the packet buffer one byte per cycle through its single read
//  port, and busy stays high until it is through. After the closing zero byte of
//  a name the same advance reads the question or answer tail; a label byte that
//  yields no character goes on to the next name byte, a pointer to its second
//  byte, and a clipped label is skipped without a read. The result strobes in the
//  cycle busy drops; status items that the idle state decides on the advance
//  itself strobe in the cycle right after the advance.
//  Reset clears all control state; buffer contents are undefined until loaded.
//  Results cannot be held off: each is strobed for exactly one cycle.
module dns_message_parser
	import dmp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [7:0]  data_byte,
	input  logic        end_of_packet,
	output logic        strobe,
	output logic [2:0]  record_kind,
	output logic [15:0] first_word,
	output logic [15:0] second_word,
	output logic [15:0] third_word,
	output logic [15:0] fourth_word,
	output logic [31:0] time_to_live,
	output logic        query_failed,
	output logic [2:0]  error_code,
	output logic        last_of_packet
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_NAME   = 5'b00010,
		S_TAIL   = 5'b00100,
		S_GATHER = 5'b01000,
		S_USE    = 5'b10000
	} state_t;

	state_t               st_q, st_d;
	phase_t               phase_q, phase_d;
	logic [CNT_W-1:0]     wc_q, wc_d;
	logic [CNT_W-1:0]     len_q, len_d;
	logic [POS_W-1:0]     rp_q, rp_d;
	logic [POS_W-1:0]     rs_q, rs_d;
	logic                 pt_q, pt_d;
	logic [HOP_W-1:0]     hop_q, hop_d;
	logic [NC_W-1:0]      nc_q, nc_d;
	logic [5:0]           ll_q, ll_d;
	logic [15:0]          ql_q, ql_d;
	logic [15:0]          al_q, al_d;
	logic [15:0]          rdl_q, rdl_d;
	gather_t              gp_q, gp_d;
	logic [3:0]           gn_q, gn_d;
	logic [3:0]           gi_q, gi_d;
	logic                 gv_q, gv_d;
	logic [POS_W-1:0]     ga_q, ga_d;
	logic [ACC_W-1:0]     acc_q, acc_d;
	item_t                out_q;
	logic                 strobe_q;

	// Per-cycle requests raised by the sequencer below.
	logic                 do_fin;
	err_t                 fin_err;
	logic                 do_gat;
	gather_t              g_p;
	logic [3:0]           g_n;
	logic [POS_W-1:0]     g_a;
	logic                 do_em;
	item_t                em;

	logic                 wr_en;
	logic                 rd_en;
	logic [ADDR_W-1:0]    rd_addr;
	logic [7:0]           rd_data;

	logic [POS_W-1:0]     at;
	logic [POS_W:0]       at_q4;
	logic [POS_W:0]       at_a10;
	logic [POS_W-1:0]     rp_new;
	logic [POS_W+1:0]     rd_end;
	logic                 rp_past;
	logic                 accept;
	logic [7:0]           lbl;

	assign accept  = start && !busy;
	assign wr_en   = accept && !command && (wc_q < CNT_W'(BUFFER_BYTES));
	assign busy    = (st_q != S_IDLE);

	// The fixed fields after a name resume after the first pointer, if one was taken.
	assign at      = pt_q ? rs_q : rp_q;
	assign at_q4   = (POS_W+1)'(at) + (POS_W+1)'(Q_FIXED);
	assign at_a10  = (POS_W+1)'(at) + (POS_W+1)'(ANS_FIXED);
	assign rp_new  = at_a10[POS_W-1:0];
	assign rd_end  = (POS_W+2)'(rp_new) + (POS_W+2)'(acc_q[15:0]);
	assign rp_past = rp_q >= POS_W'(len_q);
	assign lbl     = acc_q[7:0];

	dmp_ram #(
		.DEPTH(BUFFER_BYTES),
		.WIDTH(8)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wc_q[ADDR_W-1:0]),
		.wr_data(data_byte),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		st_d    = st_q;
		phase_d = phase_q;
		wc_d    = wc_q;
		len_d   = len_q;
		rp_d    = rp_q;
		rs_d    = rs_q;
		pt_d    = pt_q;
		hop_d   = hop_q;
		nc_d    = nc_q;
		ll_d    = ll_q;
		ql_d    = ql_q;
		al_d    = al_q;
		rdl_d   = rdl_q;
		gp_d    = gp_q;
		gn_d    = gn_q;
		gi_d    = gi_q;
		gv_d    = gv_q;
		ga_d    = ga_q;
		acc_d   = acc_q;
		do_fin  = 1'b0;
		fin_err = ERR_OK;
		do_gat  = 1'b0;
		g_p     = G_RD;
		g_n     = 4'd1;
		g_a     = rp_q;
		do_em   = 1'b0;
		em      = '0;
		rd_en   = 1'b0;
		rd_addr = ga_q[ADDR_W-1:0] + ADDR_W'(gi_q);

		unique case (st_q)
			S_IDLE: begin
				if (accept && !command) begin
					// Load: append the byte while the buffer has room, and on the end mark arm a new parse.
					if (wr_en) begin
						wc_d = wc_q + 1'b1;
					end
					if (end_of_packet) begin
						len_d   = wr_en ? wc_q + 1'b1 : wc_q;
						wc_d    = '0;
						phase_d = PH_HEADER;
						rp_d    = '0;
						rs_d    = '0;
						pt_d    = 1'b0;
						hop_d   = '0;
						nc_d    = '0;
						ll_d    = '0;
						ql_d    = '0;
						al_d    = '0;
						rdl_d   = '0;
					end
				end else if (accept) begin
					unique case (phase_q)
						PH_NONE: begin
							do_em    = 1'b1;
							em.kind  = KIND_FINISH;
							em.err   = ERR_NO_PKT;
						end
						PH_HEADER: begin
							if (len_q < CNT_W'(HDR_BYTES)) begin
								do_fin  = 1'b1;
								fin_err = ERR_SHORT;
							end else begin
								do_gat = 1'b1;
								g_p    = G_HDR;
								g_n    = 4'd4;
								g_a    = '0;
							end
						end
						PH_COUNTS: begin
							do_gat = 1'b1;
							g_p    = G_CNT;
							g_n    = 4'd8;
							g_a    = POS_W'(4);
						end
						PH_RECORD: begin
							if (ql_q == '0 && al_q == '0) begin
								do_fin  = 1'b1;
								fin_err = ERR_OK;
							end else if (rp_past) begin
								do_fin  = 1'b1;
								fin_err = ERR_NAME_OUT;
							end else begin
								nc_d    = '0;
								ll_d    = '0;
								pt_d    = 1'b0;
								hop_d   = '0;
								rs_d    = '0;
								phase_d = (ql_q != '0) ? PH_QNAME : PH_ANAME;
								st_d    = S_NAME;
							end
						end
						PH_QNAME, PH_ANAME: begin
							st_d = S_NAME;
						end
						PH_RDATA: begin
							do_gat = 1'b1;
							g_p    = G_RD;
							g_n    = 4'd1;
							g_a    = rp_q;
						end
						PH_DONE: begin
							// No more items until the next packet is loaded.
						end
						default: begin
						end
					endcase
				end
			end

			S_NAME: begin
				// One step of the name walk: read a byte, skip a clipped label,
				// or hand over to the fixed fields.
				if (rp_past) begin
					st_d = S_TAIL;
				end else if (ll_q != '0) begin
					if (nc_q < NC_W'(NAME_BUFFER - 1)) begin
						do_gat = 1'b1;
						g_p    = G_CHR;
						g_a    = rp_q;
					end else begin
						rp_d = rp_q + POS_W'(ll_q);
						ll_d = '0;
					end
				end else begin
					do_gat = 1'b1;
					g_p    = G_LBL;
					g_a    = rp_q;
				end
			end

			S_TAIL: begin
				if (phase_q == PH_QNAME) begin
					if (at_q4 > (POS_W+1)'(len_q)) begin
						do_fin  = 1'b1;
						fin_err = ERR_FIELDS;
					end else begin
						do_gat = 1'b1;
						g_p    = G_QT;
						g_n    = 4'd4;
						g_a    = at;
					end
				end else begin
					if (at_a10 > (POS_W+1)'(len_q)) begin
						do_fin  = 1'b1;
						fin_err = ERR_FIELDS;
					end else begin
						do_gat = 1'b1;
						g_p    = G_AT;
						g_n    = 4'd10;
						g_a    = at;
					end
				end
			end

			S_GATHER: begin
				// Issue one read a cycle; shift in the byte from the cycle before.
				if (gv_q) begin
					acc_d = {acc_q[ACC_W-9:0], rd_data};
				end
				if (gi_q != gn_q) begin
					rd_en = 1'b1;
					gi_d  = gi_q + 1'b1;
					gv_d  = 1'b1;
				end else begin
					gv_d = 1'b0;
					st_d = S_USE;
				end
			end

			S_USE: begin
				case (gp_q)
					G_HDR: begin
						phase_d = PH_COUNTS;
						do_em   = 1'b1;
						em.kind = KIND_HEADER;
						em.w1   = acc_q[31:16];
						em.w2   = acc_q[15:0];
						em.qf   = (acc_q[3:0] != 4'd0);
					end
					G_CNT: begin
						ql_d    = acc_q[63:48];
						al_d    = acc_q[47:32];
						rp_d    = POS_W'(HDR_BYTES);
						phase_d = PH_RECORD;
						do_em   = 1'b1;
						em.kind = KIND_COUNTS;
						em.w1   = acc_q[63:48];
						em.w2   = acc_q[47:32];
						em.w3   = acc_q[31:16];
						em.w4   = acc_q[15:0];
					end
					G_QT: begin
						rp_d    = at_q4[POS_W-1:0];
						ql_d    = ql_q - 1'b1;
						phase_d = PH_RECORD;
						do_em   = 1'b1;
						em.kind = KIND_QTAIL;
						em.w1   = acc_q[31:16];
						em.w2   = acc_q[15:0];
					end
					G_AT: begin
						rp_d = rp_new;
						if (rd_end > (POS_W+2)'(len_q)) begin
							do_fin  = 1'b1;
							fin_err = ERR_RDATA;
						end else begin
							al_d    = al_q - 1'b1;
							rdl_d   = acc_q[15:0];
							phase_d = (acc_q[15:0] != '0) ? PH_RDATA : PH_RECORD;
							do_em   = 1'b1;
							em.kind = KIND_ATAIL;
							em.w1   = acc_q[79:64];
							em.w2   = acc_q[63:48];
							em.w3   = acc_q[15:0];
							em.ttl  = acc_q[47:16];
						end
					end
					G_RD: begin
						rp_d  = rp_q + 1'b1;
						rdl_d = rdl_q - 1'b1;
						if (rdl_q == 16'd1) begin
							phase_d = PH_RECORD;
						end
						do_em   = 1'b1;
						em.kind = KIND_RDATA;
						em.w1   = {8'd0, lbl};
					end
					G_CHR: begin
						rp_d    = rp_q + 1'b1;
						ll_d    = ll_q - 1'b1;
						nc_d    = nc_q + 1'b1;
						do_em   = 1'b1;
						em.kind = KIND_CHAR;
						em.w1   = {8'd0, lbl};
					end
					G_LBL: begin
						if (lbl == 8'd0) begin
							rp_d = rp_q + 1'b1;
							st_d = S_TAIL;
						end else if ((lbl & PTR_MARK) == PTR_MARK) begin
							if (rp_q + 1'b1 >= POS_W'(len_q)) begin
								do_fin  = 1'b1;
								fin_err = ERR_LABEL;
							end else if (hop_q >= HOP_W'(MAX_HOPS)) begin
								do_fin  = 1'b1;
								fin_err = ERR_HOPS;
							end else begin
								hop_d = hop_q + 1'b1;
								if (!pt_q) begin
									rs_d = rp_q + POS_W'(2);
									pt_d = 1'b1;
								end
								do_gat = 1'b1;
								g_p    = G_PTR;
								g_a    = rp_q + 1'b1;
							end
						end else if (lbl > LABEL_MAX) begin
							do_fin  = 1'b1;
							fin_err = ERR_LABEL;
						end else begin
							rp_d = rp_q + 1'b1;
							ll_d = lbl[5:0];
							if (nc_q != '0 && nc_q < NC_W'(NAME_BUFFER - 1)) begin
								nc_d    = nc_q + 1'b1;
								do_em   = 1'b1;
								em.kind = KIND_CHAR;
								em.w1   = {8'd0, DOT_CHAR};
							end else begin
								st_d = S_NAME;
							end
						end
					end
					G_PTR: begin
						// Follow the pointer: low six bits of the first byte, then the second.
						rp_d = POS_W'({acc_q[13:8], acc_q[7:0]});
						st_d = S_NAME;
					end
					default: begin
					end
				endcase
			end

			default: begin
				st_d = S_IDLE;
			end
		endcase

		if (do_gat) begin
			st_d = S_GATHER;
			gp_d = g_p;
			gn_d = g_n;
			gi_d = '0;
			gv_d = 1'b0;
			ga_d = g_a;
		end
		if (do_fin) begin
			phase_d = PH_DONE;
			do_em   = 1'b1;
			em      = '0;
			em.kind = KIND_FINISH;
			em.err  = fin_err;
			em.last = 1'b1;
		end
		if (do_em) begin
			st_d = S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			phase_q  <= PH_NONE;
			wc_q     <= '0;
			len_q    <= '0;
			rp_q     <= '0;
			rs_q     <= '0;
			pt_q     <= 1'b0;
			hop_q    <= '0;
			nc_q     <= '0;
			ll_q     <= '0;
			ql_q     <= '0;
			al_q     <= '0;
			rdl_q    <= '0;
			gp_q     <= G_RD;
			gn_q     <= '0;
			gi_q     <= '0;
			gv_q     <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			st_q     <= st_d;
			phase_q  <= phase_d;
			wc_q     <= wc_d;
			len_q    <= len_d;
			rp_q     <= rp_d;
			rs_q     <= rs_d;
			pt_q     <= pt_d;
			hop_q    <= hop_d;
			nc_q     <= nc_d;
			ll_q     <= ll_d;
			ql_q     <= ql_d;
			al_q     <= al_d;
			rdl_q    <= rdl_d;
			gp_q     <= gp_d;
			gn_q     <= gn_d;
			gi_q     <= gi_d;
			gv_q     <= gv_d;
			strobe_q <= do_em;
		end
	end

	// Payload holds: gather address, byte accumulator and the result item.
	always_ff @(posedge clk) begin
		ga_q  <= ga_d;
		acc_q <= acc_d;
		if (do_em) begin
			out_q <= em;
		end
	end

	assign strobe         = strobe_q;
	assign record_kind    = out_q.kind;
	assign first_word     = out_q.w1;
	assign second_word    = out_q.w2;
	assign third_word     = out_q.w3;
	assign fourth_word    = out_q.w4;
	assign time_to_live   = out_q.ttl;
	assign query_failed   = out_q.qf;
	assign error_code     = out_q.err;
	assign last_of_packet = out_q.last;

endmodule

### hdl/dmp_ram.sv
// Single-port-write, single-port-read byte memory with registered read data.
`timescale 1ns / 1ps
module dmp_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hdl/dmp_checker.sv
// Port-level checks for the DNS message parser, bound to its top level.
`timescale 1ns / 1ps
module dmp_checker
	import dmp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        command,
	input logic        strobe,
	input logic [2:0]  record_kind,
	input logic [15:0] second_word,
	input logic        query_failed,
	input logic [2:0]  error_code,
	input logic        last_of_packet
);

	// A load never produces an item of its own.
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !command |=> !strobe)
		else $error("item follows a load");

	// Only the finish item carries status.
	a_status_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && record_kind != KIND_FINISH |-> error_code == ERR_OK && !last_of_packet)
		else $error("status on a non-finish item");

	// An advance with no packet does not close one.
	a_no_pkt_open: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && record_kind == KIND_FINISH && error_code == ERR_NO_PKT
		|-> !last_of_packet)
		else $error("no-packet finish marked last");

	// Header failure flag follows the response code in the flags word.
	a_rcode_flag: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && record_kind == KIND_HEADER |-> query_failed == (second_word[3:0] != 4'd0))
		else $error("query_failed disagrees with rcode");

endmodule

bind dns_message_parser dmp_checker u_dmp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.command       (command),
	.strobe        (strobe),
	.record_kind   (record_kind),
	.second_word   (second_word),
	.query_failed  (query_failed),
	.error_code    (error_code),
	.last_of_packet(last_of_packet)
);

### verif/dns_message_parser_checker.sv
// Checker for the DNS message parser: tracks accepted items, predicts results, compares.
`timescale 1ns / 1ps
module dns_message_parser_checker
	import dmp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        command,
	input  logic [7:0]  data_byte,
	input  logic        end_of_packet,
	input  logic        strobe,
	input  logic [2:0]  record_kind,
	input  logic [15:0] first_word,
	input  logic [15:0] second_word,
	input  logic [15:0] third_word,
	input  logic [15:0] fourth_word,
	input  logic [31:0] time_to_live,
	input  logic        query_failed,
	input  logic [2:0]  error_code,
	input  logic        last_of_packet,
	output int          fail_count,
	output int          pending
);

	logic [7:0]  msg_mem [BUFFER_BYTES];
	int          wr_cnt, msg_len, rpos, resume_pos, hops, nchars, lbl_left;
	bit          ptr_taken;
	logic [15:0] q_left, a_left, rd_left;
	phase_t      ph;
	item_t       parsed_q [$];

	function automatic int byte_at(int pos);
		return pos < BUFFER_BYTES ? int'(msg_mem[pos]) : 0;
	endfunction

	function automatic int word_at(int pos);
		return (byte_at(pos) << 8) | byte_at(pos + 1);
	endfunction

	function automatic item_t mk(kind_t k, int w1, int w2, int w3, int w4,
			logic [31:0] ttl, logic qf, err_t e, logic last);
		item_t r;
		r.kind = k;
		r.w1 = w1[15:0];
		r.w2 = w2[15:0];
		r.w3 = w3[15:0];
		r.w4 = w4[15:0];
		r.ttl = ttl;
		r.qf = qf;
		r.err = e;
		r.last = last;
		return r;
	endfunction

	function automatic item_t close_msg(err_t e);
		ph = PH_DONE;
		return mk(KIND_FINISH, 0, 0, 0, 0, 0, 1'b0, e, 1'b1);
	endfunction

	function automatic item_t record_tail(bit answer);
		int at, len, hi, lo;
		logic [31:0] ttl;
		at = ptr_taken ? resume_pos : rpos;
		if (!answer) begin
			if (at + Q_FIXED > msg_len)
				return close_msg(ERR_FIELDS);
			rpos = at + Q_FIXED;
			q_left = q_left - 16'd1;
			ph = PH_RECORD;
			return mk(KIND_QTAIL, word_at(at), word_at(at + 2), 0, 0, 0, 1'b0, ERR_OK, 1'b0);
		end
		if (at + ANS_FIXED > msg_len)
			return close_msg(ERR_FIELDS);
		hi = word_at(at + 4);
		lo = word_at(at + 6);
		ttl = {hi[15:0], lo[15:0]};
		len = word_at(at + 8);
		rpos = at + ANS_FIXED;
		if (rpos + len > msg_len)
			return close_msg(ERR_RDATA);
		a_left = a_left - 16'd1;
		rd_left = len[15:0];
		ph = (len != 0) ? PH_RDATA : PH_RECORD;
		return mk(KIND_ATAIL, word_at(at), word_at(at + 2), len, 0, ttl, 1'b0, ERR_OK, 1'b0);
	endfunction

	function automatic item_t name_next(bit answer);
		int b, c;
		while (1) begin
			if (lbl_left > 0) begin
				if (rpos >= msg_len)
					return record_tail(answer);
				if (nchars < NAME_BUFFER - 1) begin
					c = byte_at(rpos);
					rpos++;
					lbl_left--;
					nchars++;
					return mk(KIND_CHAR, c, 0, 0, 0, 0, 1'b0, ERR_OK, 1'b0);
				end
				// name buffer full: skip the rest of this label
				rpos += lbl_left;
				lbl_left = 0;
				continue;
			end
			if (rpos >= msg_len)
				return record_tail(answer);
			b = byte_at(rpos);
			if (b == 0) begin
				rpos++;
				return record_tail(answer);
			end
			if ((b & 'hC0) == 'hC0) begin
				if (rpos + 1 >= msg_len)
					return close_msg(ERR_LABEL);
				if (hops >= MAX_HOPS)
					return close_msg(ERR_HOPS);
				hops++;
				if (!ptr_taken) begin
					resume_pos = rpos + 2;
					ptr_taken = 1'b1;
				end
				rpos = ((b & 'h3F) << 8) | byte_at(rpos + 1);
				continue;
			end
			if (b > LABEL_MAX)
				return close_msg(ERR_LABEL);
			rpos++;
			lbl_left = b;
			if (nchars > 0 && nchars < NAME_BUFFER - 1) begin
				nchars++;
				return mk(KIND_CHAR, DOT_CHAR, 0, 0, 0, 0, 1'b0, ERR_OK, 1'b0);
			end
		end
	endfunction

	function automatic bit parse_advance(output item_t r);
		bit answer;
		case (ph)
			PH_NONE: begin
				r = mk(KIND_FINISH, 0, 0, 0, 0, 0, 1'b0, ERR_NO_PKT, 1'b0);
			end
			PH_HEADER: begin
				if (msg_len < HDR_BYTES) begin
					r = close_msg(ERR_SHORT);
				end else begin
					ph = PH_COUNTS;
					r = mk(KIND_HEADER, word_at(0), word_at(2), 0, 0, 0,
						(byte_at(3) & 'h0F) != 0, ERR_OK, 1'b0);
				end
			end
			PH_COUNTS: begin
				q_left = 16'(word_at(4));
				a_left = 16'(word_at(6));
				rpos = HDR_BYTES;
				ph = PH_RECORD;
				r = mk(KIND_COUNTS, word_at(4), word_at(6), word_at(8), word_at(10), 0,
					1'b0, ERR_OK, 1'b0);
			end
			PH_RECORD: begin
				if (q_left == 0 && a_left == 0) begin
					r = close_msg(ERR_OK);
				end else if (rpos >= msg_len) begin
					r = close_msg(ERR_NAME_OUT);
				end else begin
					answer = (q_left == 0);
					nchars = 0;
					lbl_left = 0;
					ptr_taken = 1'b0;
					hops = 0;
					resume_pos = 0;
					ph = answer ? PH_ANAME : PH_QNAME;
					r = name_next(answer);
				end
			end
			PH_QNAME: r = name_next(1'b0);
			PH_ANAME: r = name_next(1'b1);
			PH_RDATA: begin
				r = mk(KIND_RDATA, byte_at(rpos), 0, 0, 0, 0, 1'b0, ERR_OK, 1'b0);
				rpos++;
				rd_left = rd_left - 16'd1;
				if (rd_left == 0)
					ph = PH_RECORD;
			end
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic int field_diff(string fname, longint want, longint got);
		if (want == got)
			return 0;
		$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, fname, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		item_t want, r;
		int bad;
		if (!arst_n) begin
			foreach (msg_mem[i])
				msg_mem[i] = 8'h00;
			wr_cnt = 0;
			msg_len = 0;
			ph = PH_NONE;
			rpos = 0;
			resume_pos = 0;
			ptr_taken = 1'b0;
			hops = 0;
			nchars = 0;
			lbl_left = 0;
			q_left = '0;
			a_left = '0;
			rd_left = '0;
			parsed_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			bad = 0;
			// compare the result leaving the block first; it belongs to an older item
			if (strobe) begin
				if (parsed_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual kind %0d",
						$time, record_kind);
					bad++;
				end else begin
					want = parsed_q.pop_front();
					bad += field_diff("record_kind", want.kind, record_kind);
					bad += field_diff("first_word", want.w1, first_word);
					bad += field_diff("second_word", want.w2, second_word);
					bad += field_diff("third_word", want.w3, third_word);
					bad += field_diff("fourth_word", want.w4, fourth_word);
					bad += field_diff("time_to_live", want.ttl, time_to_live);
					bad += field_diff("query_failed", want.qf, query_failed);
					bad += field_diff("error_code", want.err, error_code);
					bad += field_diff("last_of_packet", want.last, last_of_packet);
				end
			end
			if (start && !busy) begin
				if (!command) begin
					if (wr_cnt < BUFFER_BYTES) begin
						msg_mem[wr_cnt] = data_byte;
						wr_cnt++;
					end
					if (end_of_packet) begin
						msg_len = wr_cnt;
						wr_cnt = 0;
						ph = PH_HEADER;
						rpos = 0;
						resume_pos = 0;
						ptr_taken = 1'b0;
						hops = 0;
						nchars = 0;
						lbl_left = 0;
						q_left = '0;
						a_left = '0;
						rd_left = '0;
					end
				end else if (parse_advance(r)) begin
					parsed_q.push_back(r);
				end
			end
			fail_count <= fail_count + (bad != 0);
			pending <= parsed_q.size();
		end
	end

endmodule

### verif/dns_message_parser_tb.sv
// Testbench top for the DNS message parser: builds messages, drives items, gives the verdict.
`timescale 1ns / 1ps
module dns_message_parser_tb;
	import dmp_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int ADVANCE_CAP = 800;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        command;
	logic [7:0]  data_byte;
	logic        end_of_packet;
	logic        strobe;
	logic [2:0]  record_kind;
	logic [15:0] first_word, second_word, third_word, fourth_word;
	logic [31:0] time_to_live;
	logic        query_failed;
	logic [2:0]  error_code;
	logic        last_of_packet;
	int          fail_count, pending;

	int          finish_seen;   // finish items seen on the result port
	int          stall_cycles;
	int          items_sent;
	bit          burst;         // no gaps for the whole message
	logic [7:0]  msg [$];       // message under construction
	int          name_home;     // offset of the first name, target of pointers

	dns_message_parser uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .data_byte(data_byte), .end_of_packet(end_of_packet),
		.strobe(strobe), .record_kind(record_kind), .first_word(first_word),
		.second_word(second_word), .third_word(third_word), .fourth_word(fourth_word),
		.time_to_live(time_to_live), .query_failed(query_failed),
		.error_code(error_code), .last_of_packet(last_of_packet)
	);

	dns_message_parser_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .data_byte(data_byte), .end_of_packet(end_of_packet),
		.strobe(strobe), .record_kind(record_kind), .first_word(first_word),
		.second_word(second_word), .third_word(third_word), .fourth_word(fourth_word),
		.time_to_live(time_to_live), .query_failed(query_failed),
		.error_code(error_code), .last_of_packet(last_of_packet),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Count finish items so the sender knows when a message is fully parsed.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			finish_seen <= 0;
		end else if (strobe && record_kind == KIND_FINISH) begin
			finish_seen <= finish_seen + 1;
		end
	end

	// Watchdog: end the run when nothing is accepted for too long.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if (start && !busy) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("[dns_message_parser] ERROR");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Present one item and hold it until the block takes it. Keep start high
	// when there is no gap, so that back-to-back items never drop it.
	task automatic issue(logic cmd, logic [7:0] b, logic eop);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		data_byte <= b;
		end_of_packet <= eop;
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	task automatic load_range(int from, int upto, bit mark_end);
		for (int i = from; i < upto; i++)
			issue(1'b0, msg[i], mark_end && (i == upto - 1));
	endtask

	// Advance until a finish item shows up; a spare advance after it is ignored.
	task automatic advance_to_finish();
		int snap;
		snap = finish_seen;
		for (int n = 0; n < ADVANCE_CAP && finish_seen == snap; n++)
			issue(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	function automatic void put16(int v);
		msg.push_back(v[15:8]);
		msg.push_back(v[7:0]);
	endfunction

	function automatic void put_name(bit long_nm);
		int nlab, len;
		if (name_home > 0 && $urandom_range(0, 2) == 0) begin
			put16('hC000 | name_home);
			return;
		end
		if (name_home == 0)
			name_home = msg.size();
		nlab = long_nm ? 5 : $urandom_range(0, 3);
		for (int l = 0; l < nlab; l++) begin
			len = long_nm ? LABEL_MAX : $urandom_range(1, 6);
			msg.push_back(8'(len));
			repeat (len) msg.push_back(8'($urandom_range(0, 255)));
		end
		if (name_home != msg.size() && $urandom_range(0, 3) == 0)
			put16('hC000 | name_home);
		else
			msg.push_back(8'h00);
	endfunction

	// Build a well-formed message with random content.
	function automatic void build_msg(bit long_nm);
		int qd, an, rdl;
		msg.delete();
		name_home = 0;
		qd = $urandom_range(0, 2);
		an = $urandom_range(0, 2);
		put16($urandom_range(0, 'hFFFF));
		put16($urandom_range(0, 'hFFFF));
		put16(qd);
		put16(an);
		put16($urandom_range(0, 'hFFFF));
		put16($urandom_range(0, 'hFFFF));
		for (int q = 0; q < qd; q++) begin
			put_name(long_nm && q == 0);
			put16($urandom_range(0, 'hFFFF));
			put16($urandom_range(0, 'hFFFF));
		end
		for (int a = 0; a < an; a++) begin
			put_name(1'b0);
			put16($urandom_range(0, 'hFFFF));
			put16($urandom_range(0, 'hFFFF));
			put16($urandom_range(0, 'hFFFF));
			put16($urandom_range(0, 'hFFFF));
			rdl = $urandom_range(0, 5);
			put16(rdl);
			repeat (rdl) msg.push_back(8'($urandom_range(0, 255)));
		end
	endfunction

	// Load the message, parse it; sometimes rewrite its first bytes mid-parse
	// and then finish the rewrite so the same message is parsed again.
	task automatic run_msg();
		int cut, early;
		if (msg.size() == 0)
			msg.push_back(8'($urandom_range(0, 255)));
		load_range(0, msg.size(), 1'b1);
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, msg.size());
			early = $urandom_range(1, 4);
			for (int n = 0; n < early; n++)
				issue(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			load_range(0, cut - 1, 1'b0);
			advance_to_finish();
			load_range(cut - 1, msg.size(), 1'b1);
		end
		advance_to_finish();
	endtask

	task automatic header_only(int id, int flags, int qd, int an);
		msg.delete();
		put16(id);
		put16(flags);
		put16(qd);
		put16(an);
		put16(0);
		put16(0);
	endtask

	initial begin
		int pick, pos;
		arst_n = 1'b0;
		start = 1'b0;
		command = 1'b0;
		data_byte = 8'h00;
		end_of_packet = 1'b0;
		items_sent = 0;
		burst = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: advance with nothing loaded, end flag set on the advance.
		issue(1'b1, 8'hFF, 1'b1);
		issue(1'b1, 8'h00, 1'b0);
		// Message shorter than a header.
		msg = '{8'hAB, 8'hCD, 8'h01, 8'h02, 8'h03};
		run_msg();
		// All-ones id and flags, nonzero rcode, no records.
		header_only('hFFFF, 'hFFFF, 0, 0);
		run_msg();
		// Question promised but name starts at the end.
		header_only(0, 0, 1, 0);
		run_msg();
		// Pointer to itself: hop limit.
		header_only(1, 0, 1, 0);
		put16('hC00C);
		run_msg();
		// Bad label byte, then a pointer cut by the end.
		header_only(2, 0, 1, 0);
		msg.push_back(8'h40);
		run_msg();
		header_only(3, 0, 1, 0);
		msg.push_back(8'hC0);
		run_msg();
		// Pointer beyond the end, then question fields missing.
		header_only(4, 0, 1, 0);
		put16('hFFFF);
		run_msg();
		// Answer with rdata length past the end.
		header_only(5, 'h8000, 0, 1);
		msg.push_back(8'h00);
		put16(1);
		put16(1);
		put16('hFFFF);
		put16('hFFFF);
		put16('hFFFF);
		run_msg();

		// Random: mostly well-formed messages, some broken or pure noise.
		// Leave room for the oversized message at the end.
		while (items_sent < 1000 - BUFFER_BYTES - 40) begin
			burst = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 19);
			build_msg(pick == 19);
			if (pick inside {[13:14]}) begin
				// cut short
				pos = $urandom_range(1, msg.size());
				while (msg.size() > pos)
					void'(msg.pop_back());
			end else if (pick inside {[15:16]}) begin
				// corrupt one byte
				pos = $urandom_range(0, msg.size() - 1);
				msg[pos] = 8'($urandom_range(0, 255));
			end else if (pick inside {[17:18]}) begin
				// noise
				msg.delete();
				repeat ($urandom_range(1, 40)) msg.push_back(8'($urandom_range(0, 255)));
			end
			run_msg();
			// hold until everything expected has arrived
			start <= 1'b0;
			@(posedge clk);
			while (pending != 0)
				@(posedge clk);
		end

		// One message larger than the buffer; bytes past the end are dropped.
		burst = 1'b1;
		header_only('h1234, 0, 0, 0);
		repeat (BUFFER_BYTES) msg.push_back(8'($urandom_range(0, 255)));
		run_msg();

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("[dns_message_parser] OK");
		end else begin
			$display("[dns_message_parser] ERROR");
		end
		$finish;
	end

endmodule
